FILE: hw/rtl/ffba_pkg.sv
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int HEADER_BYTES = 40;
  localparam int MAX_BLOCKS   = 64;
  localparam int ARENA_BYTES  = 65536;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = IDX_W + 1;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] size;
    logic        free;
  } entry_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] req_size;
    logic [15:0] addr;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_addr;
    logic [15:0] copy_bytes;
  } out_t;

endpackage

FILE: hw/rtl/ffba_table.sv
`timescale 1ns / 1ps
module ffba_table (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [ffba_pkg::IDX_W-1:0] rd_idx,
  output ffba_pkg::entry_t           rd_q,
  input  logic                       wr_en,
  input  logic [ffba_pkg::IDX_W-1:0] wr_idx,
  input  ffba_pkg::entry_t           wr_data
);
  import ffba_pkg::*;

  entry_t mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

endmodule

FILE: hw/rtl/first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
// first-fit block allocator: metadata engine of a growing arena
// input channel in_valid / in_stall carries one request (allocate, release,
// resize); a transfer takes place when in_valid is high and in_stall low.
// every request gives exactly one result on out_valid / out_stall.
// cfg_valid / cfg_ready writes heap_limit; cfg_ready is always high and a
// write is meant to be made while no request is in flight.
// the block table sits in one synchronous memory of 64 entries; each table
// access is a read state followed by a check or write state. a request
// runs through scans and walks: a first-fit or lookup scan covers up to the
// block count, and an insert or remove walk moves the entries above the
// changed position. a release of zero and an unused op skip the table; a
// moving resize runs two lookups, a fit scan and up to three walks. in_stall
// stays high from the transfer until the result is loaded into the output
// register.
// the output register holds a result while out_stall is high; the engine
// then waits in its final state. reset (rst_n low, synchronous) empties the
// table and heap, sets heap_limit to 65536 and needs no clearing pass.
module first_fit_block_allocator_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ffba_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ffba_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [16:0]     cfg_data
);
  import ffba_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_SC_RD    = 5'd1;
  localparam logic [4:0] S_SC_CK    = 5'd2;
  localparam logic [4:0] S_AL_POST  = 5'd3;
  localparam logic [4:0] S_AL_WB    = 5'd4;
  localparam logic [4:0] S_AL_END   = 5'd5;
  localparam logic [4:0] S_INS_RD   = 5'd6;
  localparam logic [4:0] S_INS_WR   = 5'd7;
  localparam logic [4:0] S_RM_RD    = 5'd8;
  localparam logic [4:0] S_RM_WR    = 5'd9;
  localparam logic [4:0] S_REL_HIT  = 5'd10;
  localparam logic [4:0] S_REL_ST   = 5'd11;
  localparam logic [4:0] S_REL_PREV = 5'd12;
  localparam logic [4:0] S_REL_NX   = 5'd13;
  localparam logic [4:0] S_REL_NXCK = 5'd14;
  localparam logic [4:0] S_WB_FIN   = 5'd15;
  localparam logic [4:0] S_RSZ_POST = 5'd16;
  localparam logic [4:0] S_RSZ_NX   = 5'd17;
  localparam logic [4:0] S_RSZ_SPL  = 5'd18;
  localparam logic [4:0] S_RSZ_MOVE = 5'd19;
  localparam logic [4:0] S_FIN      = 5'd20;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
  localparam logic [16:0]      HDR17   = 17'(HEADER_BYTES);
  localparam logic [16:0]      MIN_REM = 17'(HEADER_BYTES + 8);
  localparam logic [16:0]      LIM_MAX = (ARENA_BYTES < 65536) ? 17'(ARENA_BYTES) : 17'd65536;

  logic [4:0]       state_r, state_nxt, ret_r, ret_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, j_r, j_nxt, ci_r, ci_nxt, pos_r, pos_nxt;
  logic [16:0]      top_r, top_nxt, limit_r, limit_nxt, s_r, s_nxt;
  logic [15:0]      a_r, a_nxt, res_r, res_nxt, copy_r, copy_nxt;
  logic [15:0]      old_r, old_nxt, nsz_r, nsz_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             kind_r, kind_nxt, hit_r, hit_nxt, mv_r, mv_nxt;
  entry_t           cur_r, cur_nxt, ins_r, ins_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  entry_t           rd_q, wr_data;

  logic [16:0] lim, csz, rsz, rem;
  logic [17:0] app_a;
  logic [18:0] app_end;
  logic        match;

  ffba_table u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_q    (rd_q),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data)
  );

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    lim     = (limit_r > LIM_MAX) ? LIM_MAX : limit_r;
    csz     = {1'b0, cur_r.size};
    rsz     = {1'b0, rd_q.size};
    rem     = csz - s_r;
    app_a   = {1'b0, top_r} + {1'b0, HDR17};
    app_end = {1'b0, app_a} + {2'b00, s_r};
    match   = kind_r ? (rd_q.free && (rsz >= s_r)) : (rd_q.addr == a_r);
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    count_nxt     = count_r;
    j_nxt         = j_r;
    ci_nxt        = ci_r;
    pos_nxt       = pos_r;
    top_nxt       = top_r;
    limit_nxt     = limit_r;
    s_nxt         = s_r;
    a_nxt         = a_r;
    res_nxt       = res_r;
    copy_nxt      = copy_r;
    old_nxt       = old_r;
    nsz_nxt       = nsz_r;
    status_nxt    = status_r;
    kind_nxt      = kind_r;
    hit_nxt       = hit_r;
    mv_nxt        = mv_r;
    cur_nxt       = cur_r;
    ins_nxt       = ins_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_idx        = j_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_idx        = ci_r[IDX_W-1:0];
    wr_data       = cur_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid) begin
      limit_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          s_nxt      = ({1'b0, in_data.req_size} + 17'd7) & ~17'h7;
          a_nxt      = in_data.addr;
          status_nxt = ST_OK;
          res_nxt    = '0;
          copy_nxt   = '0;
          mv_nxt     = 1'b0;
          j_nxt      = '0;
          case (in_data.op)
            OP_ALLOC: begin
              kind_nxt  = 1'b1;
              ret_nxt   = S_AL_POST;
              state_nxt = S_SC_RD;
            end
            OP_FREE: begin
              kind_nxt  = 1'b0;
              ret_nxt   = S_REL_HIT;
              state_nxt = (in_data.addr == '0) ? S_FIN : S_SC_RD;
            end
            OP_RESIZE: begin
              kind_nxt  = (in_data.addr == '0);
              ret_nxt   = (in_data.addr == '0) ? S_AL_POST : S_RSZ_POST;
              state_nxt = S_SC_RD;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      // table scan, for an address or for the first free fit
      S_SC_RD: begin
        if (j_r >= count_r) begin
          hit_nxt   = 1'b0;
          state_nxt = ret_r;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_SC_CK;
        end
      end
      S_SC_CK: begin
        if (match) begin
          hit_nxt   = 1'b1;
          ci_nxt    = j_r;
          cur_nxt   = rd_q;
          state_nxt = ret_r;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_SC_RD;
        end
      end

      S_AL_POST: begin
        if (hit_r) begin
          cur_nxt.free = 1'b0;
          if (rem >= MIN_REM && count_r < CNT_MAX) begin
            ins_nxt.addr = 16'({1'b0, cur_r.addr} + s_r + HDR17);
            ins_nxt.size = 16'(rem - HDR17);
            ins_nxt.free = 1'b1;
            cur_nxt.size = s_r[15:0];
            pos_nxt      = ci_r + 1'b1;
            j_nxt        = count_r;
            ret_nxt      = S_AL_WB;
            state_nxt    = S_INS_RD;
          end else begin
            state_nxt = S_AL_WB;
          end
        end else if (count_r >= CNT_MAX || app_a > 18'hFFFF || app_end > {2'b00, lim}) begin
          res_nxt   = '0;
          state_nxt = S_AL_END;
        end else begin
          wr_en        = 1'b1;
          wr_idx       = count_r[IDX_W-1:0];
          wr_data.addr = app_a[15:0];
          wr_data.size = s_r[15:0];
          wr_data.free = 1'b0;
          count_nxt    = count_r + 1'b1;
          top_nxt      = app_end[16:0];
          res_nxt      = app_a[15:0];
          nsz_nxt      = s_r[15:0];
          state_nxt    = S_AL_END;
        end
      end
      S_AL_WB: begin
        wr_en     = 1'b1;
        res_nxt   = cur_r.addr;
        nsz_nxt   = cur_r.size;
        state_nxt = S_AL_END;
      end
      S_AL_END: begin
        if (res_r == '0) begin
          status_nxt = ST_NOSPACE;
          state_nxt  = S_FIN;
        end else if (mv_r) begin
          copy_nxt  = (old_r < nsz_r) ? old_r : nsz_r;
          kind_nxt  = 1'b0;
          j_nxt     = '0;
          ret_nxt   = S_REL_ST;
          state_nxt = S_SC_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      // insert ins_r at pos_r, moving entries up
      S_INS_RD: begin
        if (j_r > pos_r) begin
          rd_en     = 1'b1;
          rd_idx    = IDX_W'(j_r - 1'b1);
          state_nxt = S_INS_WR;
        end else begin
          wr_en     = 1'b1;
          wr_idx    = pos_r[IDX_W-1:0];
          wr_data   = ins_r;
          count_nxt = count_r + 1'b1;
          state_nxt = ret_r;
        end
      end
      S_INS_WR: begin
        wr_en     = 1'b1;
        wr_idx    = j_r[IDX_W-1:0];
        wr_data   = rd_q;
        j_nxt     = j_r - 1'b1;
        state_nxt = S_INS_RD;
      end

      // remove the entry at pos_r, moving entries down
      S_RM_RD: begin
        if (j_r < count_r) begin
          rd_en     = 1'b1;
          state_nxt = S_RM_WR;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = ret_r;
        end
      end
      S_RM_WR: begin
        wr_en     = 1'b1;
        wr_idx    = IDX_W'(j_r - 1'b1);
        wr_data   = rd_q;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_RM_RD;
      end

      S_REL_HIT: begin
        if (hit_r) begin
          state_nxt = S_REL_ST;
        end else begin
          status_nxt = ST_BADADDR;
          state_nxt  = S_FIN;
        end
      end
      S_REL_ST: begin
        cur_nxt.free = 1'b1;
        if (ci_r != '0) begin
          rd_en     = 1'b1;
          rd_idx    = IDX_W'(ci_r - 1'b1);
          state_nxt = S_REL_PREV;
        end else begin
          state_nxt = S_REL_NX;
        end
      end
      S_REL_PREV: begin
        if (rd_q.free) begin
          cur_nxt.addr = rd_q.addr;
          cur_nxt.size = 16'(rsz + HDR17 + csz);
          pos_nxt      = ci_r;
          j_nxt        = ci_r + 1'b1;
          ci_nxt       = ci_r - 1'b1;
          ret_nxt      = S_REL_NX;
          state_nxt    = S_RM_RD;
        end else begin
          state_nxt = S_REL_NX;
        end
      end
      S_REL_NX: begin
        if (ci_r + 1'b1 < count_r) begin
          rd_en     = 1'b1;
          rd_idx    = IDX_W'(ci_r + 1'b1);
          state_nxt = S_REL_NXCK;
        end else begin
          // last block goes back to the heap
          top_nxt   = {1'b0, cur_r.addr} - HDR17;
          count_nxt = count_r - 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_REL_NXCK: begin
        if (rd_q.free) begin
          cur_nxt.size = 16'(csz + HDR17 + rsz);
          pos_nxt      = ci_r + 1'b1;
          j_nxt        = ci_r + 2'd2;
          ret_nxt      = S_WB_FIN;
          state_nxt    = S_RM_RD;
        end else begin
          state_nxt = S_WB_FIN;
        end
      end
      S_WB_FIN: begin
        wr_en     = 1'b1;
        state_nxt = S_FIN;
      end

      S_RSZ_POST: begin
        if (!hit_r) begin
          status_nxt = ST_BADADDR;
          state_nxt  = S_FIN;
        end else if (csz >= s_r) begin
          state_nxt = S_RSZ_SPL;
        end else if (ci_r + 1'b1 < count_r) begin
          rd_en     = 1'b1;
          rd_idx    = IDX_W'(ci_r + 1'b1);
          state_nxt = S_RSZ_NX;
        end else begin
          state_nxt = S_RSZ_MOVE;
        end
      end
      S_RSZ_NX: begin
        if (rd_q.free && (csz + HDR17 + rsz >= s_r)) begin
          cur_nxt.size = 16'(csz + HDR17 + rsz);
          pos_nxt      = ci_r + 1'b1;
          j_nxt        = ci_r + 2'd2;
          ret_nxt      = S_RSZ_SPL;
          state_nxt    = S_RM_RD;
        end else begin
          state_nxt = S_RSZ_MOVE;
        end
      end
      S_RSZ_SPL: begin
        res_nxt = a_r;
        if (rem >= MIN_REM && count_r < CNT_MAX) begin
          ins_nxt.addr = 16'({1'b0, cur_r.addr} + s_r + HDR17);
          ins_nxt.size = 16'(rem - HDR17);
          ins_nxt.free = 1'b1;
          cur_nxt.size = s_r[15:0];
          pos_nxt      = ci_r + 1'b1;
          j_nxt        = count_r;
          ret_nxt      = S_WB_FIN;
          state_nxt    = S_INS_RD;
        end else begin
          state_nxt = S_WB_FIN;
        end
      end
      S_RSZ_MOVE: begin
        old_nxt   = cur_r.size;
        mv_nxt    = 1'b1;
        kind_nxt  = 1'b1;
        j_nxt     = '0;
        ret_nxt   = S_AL_POST;
        state_nxt = S_SC_RD;
      end

      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = status_r;
          out_nxt.result_addr = (status_r == ST_OK) ? res_r : '0;
          out_nxt.copy_bytes  = (status_r == ST_OK) ? copy_r : '0;
          state_nxt           = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      top_r       <= '0;
      limit_r     <= 17'd65536;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r    <= ret_nxt;
    j_r      <= j_nxt;
    ci_r     <= ci_nxt;
    pos_r    <= pos_nxt;
    s_r      <= s_nxt;
    a_r      <= a_nxt;
    res_r    <= res_nxt;
    copy_r   <= copy_nxt;
    old_r    <= old_nxt;
    nsz_r    <= nsz_nxt;
    status_r <= status_nxt;
    kind_r   <= kind_nxt;
    hit_r    <= hit_nxt;
    mv_r     <= mv_nxt;
    cur_r    <= cur_nxt;
    ins_r    <= ins_nxt;
    out_r    <= out_nxt;
  end

endmodule

FILE: verif/tb_first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
module tb_first_fit_block_allocator_core;
  import ffba_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM   = 700;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [16:0] cfg_data;

  first_fit_block_allocator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow arena state
  int unsigned blk_addr [MAX_BLOCKS];
  int unsigned blk_size [MAX_BLOCKS];
  bit blk_free [MAX_BLOCKS];
  int unsigned blk_count;
  int unsigned arena_top;
  int unsigned arena_limit;

  out_t pending_results[$];
  int unsigned live_addrs[$];
  int errors;
  int n_sent;
  int n_got;
  int idle_cycles;
  bit hold_off;
  bit long_hold_req;

  function automatic int locate_entry(int unsigned a);
    if (a == 0) return -1;
    for (int i = 0; i < blk_count; i++)
      if (blk_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic void tab_insert(int unsigned i, int unsigned a, int unsigned sz, bit fr);
    if (blk_count >= MAX_BLOCKS || i > blk_count) return;
    for (int j = blk_count; j > i; j--) begin
      blk_addr[j] = blk_addr[j-1];
      blk_size[j] = blk_size[j-1];
      blk_free[j] = blk_free[j-1];
    end
    blk_addr[i] = a;
    blk_size[i] = sz;
    blk_free[i] = fr;
    blk_count++;
  endfunction

  function automatic void tab_remove(int unsigned i);
    if (i >= blk_count) return;
    for (int j = i; j + 1 < blk_count; j++) begin
      blk_addr[j] = blk_addr[j+1];
      blk_size[j] = blk_size[j+1];
      blk_free[j] = blk_free[j+1];
    end
    blk_count--;
  endfunction

  function automatic void carve_entry(int unsigned i, int unsigned s);
    int unsigned sz;
    sz = blk_size[i];
    if (sz < s || sz - s < HEADER_BYTES + 8 || blk_count >= MAX_BLOCKS) return;
    tab_insert(i + 1, blk_addr[i] + s + HEADER_BYTES, sz - s - HEADER_BYTES, 1'b1);
    blk_size[i] = s;
  endfunction

  function automatic void absorb_next(int unsigned i);
    if (i + 1 < blk_count && blk_free[i+1]) begin
      blk_size[i] += HEADER_BYTES + blk_size[i+1];
      tab_remove(i + 1);
    end
  endfunction

  function automatic int unsigned grant_block(int unsigned s);
    int unsigned lim;
    int unsigned a;
    for (int i = 0; i < blk_count; i++)
      if (blk_free[i] && blk_size[i] >= s) begin
        carve_entry(i, s);
        blk_free[i] = 1'b0;
        return blk_addr[i];
      end
    lim = arena_limit;
    if (lim > ARENA_BYTES) lim = ARENA_BYTES;
    if (lim > 65536) lim = 65536;
    a = arena_top + HEADER_BYTES;
    if (blk_count >= MAX_BLOCKS || a > 16'hFFFF || a + s > lim) return 0;
    tab_insert(blk_count, a, s, 1'b0);
    arena_top = a + s;
    return a;
  endfunction

  function automatic void drop_block(int unsigned i);
    if (i >= blk_count) return;
    blk_free[i] = 1'b1;
    if (i > 0 && blk_free[i-1]) begin
      i--;
      absorb_next(i);
    end
    if (i + 1 < blk_count) absorb_next(i);
    else begin
      arena_top = blk_addr[i] - HEADER_BYTES;
      tab_remove(i);
    end
  endfunction

  function automatic out_t predict_request(in_t rq);
    out_t r;
    int unsigned s;
    int unsigned a;
    int idx;
    int ni;
    int unsigned old_sz;
    int unsigned new_sz;
    int unsigned na;
    r = '0;
    s = (int'(rq.req_size) + 7) & ~32'h7;
    a = rq.addr;
    if (rq.op == OP_ALLOC || (rq.op == OP_RESIZE && a == 0)) begin
      na = grant_block(s);
      r.result_addr = na[15:0];
      if (na == 0) r.status = ST_NOSPACE;
    end else if (rq.op == OP_FREE) begin
      if (a != 0) begin
        idx = locate_entry(a);
        if (idx < 0) r.status = ST_BADADDR;
        else drop_block(idx);
      end
    end else if (rq.op == OP_RESIZE) begin
      idx = locate_entry(a);
      if (idx < 0) r.status = ST_BADADDR;
      else if (blk_size[idx] >= s) begin
        carve_entry(idx, s);
        r.result_addr = a[15:0];
      end else if (idx + 1 < blk_count && blk_free[idx+1] &&
                   blk_size[idx] + HEADER_BYTES + blk_size[idx+1] >= s) begin
        absorb_next(idx);
        carve_entry(idx, s);
        r.result_addr = a[15:0];
      end else begin
        old_sz = blk_size[idx];
        na = grant_block(s);
        if (na == 0) r.status = ST_NOSPACE;
        else begin
          ni = locate_entry(na);
          new_sz = (ni >= 0) ? blk_size[ni] : s;
          r.copy_bytes = (old_sz < new_sz ? old_sz : new_sz);
          idx = locate_entry(a);
          if (idx >= 0) drop_block(idx);
          r.result_addr = na[15:0];
        end
      end
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (1500) @(posedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!hold_off && $urandom_range(0, 3) == 0) begin
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      n_got++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h", $time, out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.status !== exp_r.status) begin
          errors++;
          $display("%0t status exp %0d got %0d", $time, exp_r.status, out_data.status);
        end
        if (out_data.result_addr !== exp_r.result_addr) begin
          errors++;
          $display("%0t result_addr exp %0d got %0d", $time, exp_r.result_addr,
                   out_data.result_addr);
        end
        if (out_data.copy_bytes !== exp_r.copy_bytes) begin
          errors++;
          $display("%0t copy_bytes exp %0d got %0d", $time, exp_r.copy_bytes,
                   out_data.copy_bytes);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("first_fit_block_allocator_core: mismatch");
      $finish;
    end
  end

  task automatic send_request(input in_t rq, input bit chk, input out_t want);
    out_t p;
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_request(rq);
    if (rq.op == OP_ALLOC || rq.op == OP_RESIZE)
      if (p.status == ST_OK && p.result_addr != 0) live_addrs.push_back(p.result_addr);
    if (chk && p !== want) begin
      errors++;
      $display("%0t table row exp %h predictor %h", $time, want, p);
    end
    pending_results.push_back(p);
    n_sent++;
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 24) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(input logic [16:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    arena_limit = v;
  endtask

  function automatic in_t random_request();
    in_t rq;
    int k;
    rq.op = $urandom_range(0, 9) < 5 ? OP_ALLOC : ($urandom_range(0, 1) ? OP_FREE : OP_RESIZE);
    if ($urandom_range(0, 39) == 0) rq.op = OP_RSVD;
    k = $urandom_range(0, 19);
    rq.req_size = (k == 0) ? 16'($urandom) : (k < 4 ? 16'($urandom_range(0, 4000))
                                                    : 16'($urandom_range(0, 300)));
    if (live_addrs.size() != 0 && $urandom_range(0, 9) < 8) begin
      k = $urandom_range(0, live_addrs.size() - 1);
      rq.addr = live_addrs[k];
      if (rq.op == OP_FREE) live_addrs.delete(k);
    end else begin
      rq.addr = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    end
    return rq;
  endfunction

  typedef struct {
    in_t rq;
    bit chk;
    out_t want;
  } stim_row_t;

  stim_row_t dir_rows[$];
  stim_row_t row;

  function automatic stim_row_t mk(logic [1:0] op, logic [15:0] sz, logic [15:0] a, bit chk,
                                   logic [1:0] st, logic [15:0] ra, logic [15:0] cp);
    stim_row_t r;
    r.rq = '{op: op, req_size: sz, addr: a};
    r.chk = chk;
    r.want = '{status: st, result_addr: ra, copy_bytes: cp};
    return r;
  endfunction

  initial begin
    logic [16:0] limits [4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_off = 1'b0;
    long_hold_req = 1'b0;
    errors = 0;
    n_sent = 0;
    n_got = 0;
    idle_cycles = 0;
    blk_count = 0;
    arena_top = 0;
    arena_limit = 65536;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows.push_back(mk(OP_FREE, 0, 0, 1, ST_OK, 0, 0));
    dir_rows.push_back(mk(OP_FREE, 0, 16'h1234, 1, ST_BADADDR, 0, 0));
    dir_rows.push_back(mk(OP_RESIZE, 0, 16'hFFFF, 1, ST_BADADDR, 0, 0));
    dir_rows.push_back(mk(OP_RSVD, 16'hFFFF, 16'hFFFF, 1, ST_OK, 0, 0));
    dir_rows.push_back(mk(OP_ALLOC, 16'hFFFF, 0, 1, ST_NOSPACE, 0, 0));
    dir_rows.push_back(mk(OP_ALLOC, 1, 0, 1, ST_OK, 40, 0));
    dir_rows.push_back(mk(OP_ALLOC, 0, 0, 1, ST_OK, 88, 0));
    dir_rows.push_back(mk(OP_RESIZE, 200, 0, 1, ST_OK, 128, 0));
    dir_rows.push_back(mk(OP_ALLOC, 16, 0, 1, ST_OK, 368, 0));
    dir_rows.push_back(mk(OP_FREE, 0, 128, 1, ST_OK, 0, 0));
    dir_rows.push_back(mk(OP_FREE, 0, 128, 0, ST_OK, 0, 0));
    dir_rows.push_back(mk(OP_ALLOC, 64, 0, 0, ST_OK, 0, 0));
    dir_rows.push_back(mk(OP_RESIZE, 8, 40, 0, ST_OK, 0, 0));
    dir_rows.push_back(mk(OP_RESIZE, 100, 88, 0, ST_OK, 0, 0));
    dir_rows.push_back(mk(OP_RESIZE, 500, 40, 0, ST_OK, 0, 0));
    dir_rows.push_back(mk(OP_RESIZE, 16'hFFF9, 88, 0, ST_OK, 0, 0));
    dir_rows.push_back(mk(OP_FREE, 0, 368, 0, ST_OK, 0, 0));
    dir_rows.push_back(mk(OP_ALLOC, 16'hAAAA, 0, 0, ST_OK, 0, 0));
    dir_rows.push_back(mk(OP_ALLOC, 16'h5555, 0, 0, ST_OK, 0, 0));
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_request(row.rq, row.chk, row.want);
    end
    drain_results();

    // fill the table with tiny blocks to hit the block limit
    for (int i = 0; i < MAX_BLOCKS + 2; i++)
      send_request('{op: OP_ALLOC, req_size: 16'(i % 3), addr: 16'h0}, 1'b0, '0);
    drain_results();

    limits = '{17'd0, 17'd1024, 17'h1FFFF, 17'd65536};
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      if (ph == 1) long_hold_req = 1'b1;
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        send_request(random_request(), 1'b0, '0);
        // drain the arena now and then so allocation stays in range
        if ($urandom_range(0, 99) == 0) begin
          while (live_addrs.size() != 0)
            send_request('{op: OP_FREE, req_size: 16'($urandom), addr: live_addrs.pop_front()},
                         1'b0, '0);
        end
      end
      drain_results();
    end

    $display("sent %0d requests, checked %0d results, heap limits 0 to 131071", n_sent, n_got);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("first_fit_block_allocator_core: match");
    end else begin
      $display("first_fit_block_allocator_core: mismatch");
    end
    $finish;
  end

endmodule
